// File: design/tss_pkg.sv
// Shared types and constants of the tone step sequencer.
package tss_pkg;

    localparam int TABLE_STEPS = 256;
    localparam int ADDR_W      = $clog2(TABLE_STEPS);
    localparam int MAX_LENGTH  = 256;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  step_slot;
        logic [15:0] step_frequency;
        logic [15:0] step_duration;
        logic [15:0] step_gap;
        logic [8:0]  seq_length;
    } item_t;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_frequency;
        logic        playing;
        logic [8:0]  step_index;
    } result_t;

    typedef struct packed {
        logic [15:0] frequency;
        logic [15:0] duration;
        logic [15:0] gap;
    } step_entry_t;

endpackage

// File: design/tone_step_sequencer.sv
// Tone step sequencer top level: step table, playback state and result buffering.
//
//  channel   signals                       carries
//  item      item_valid / item_ready       tick, step write, start or stop (item_t)
//  result    result_valid / result_ready   tone and playback state after each item
//  config    cfg_write / cfg_wdata         enable register, written at once
//
// One item per cycle while the skid stage is empty; each item is accepted and its
// result registered in the same edge. The table RAM is read ahead at the index the
// state moves to, with a bypass for a write to that entry; entry 0 is shadowed in
// flops for starts. The result register and skid stage let one item enter while a
// result is stalled. Reset clears playback state; table contents stay undefined.
module tone_step_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tss_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output tss_pkg::result_t result,
    input  logic             cfg_write,
    input  logic             cfg_wdata
);

    logic                       enable_reg;
    logic [8:0]                 current_index_reg;
    logic [8:0]                 current_index_next;
    logic [8:0]                 sequence_length_reg;
    logic [8:0]                 sequence_length_next;
    logic [15:0]                ticks_left_reg;
    logic [15:0]                ticks_left_next;
    logic                       sounding_reg;
    logic                       sounding_next;
    logic                       running_reg;
    logic                       running_next;
    logic [15:0]                current_frequency_reg;
    logic [15:0]                current_frequency_next;

    tss_pkg::step_entry_t       entry0_reg;
    tss_pkg::step_entry_t       fwd_data_reg;
    logic                       fwd_hit_reg;
    tss_pkg::step_entry_t       ram_rdata;
    tss_pkg::step_entry_t       cur_entry;
    tss_pkg::step_entry_t       wr_entry;
    logic [tss_pkg::ADDR_W-1:0] ram_waddr;
    logic [tss_pkg::ADDR_W-1:0] ram_raddr;
    logic                       ram_we;

    logic                       accept;
    logic                       index_in_table;
    logic                       slot_in_table;
    logic [8:0]                 index_inc;
    logic [8:0]                 len_sat;
    tss_pkg::result_t           push_data;

    assign accept         = item_valid && item_ready;
    assign index_in_table = 32'(current_index_reg) < 32'(tss_pkg::TABLE_STEPS);
    assign slot_in_table  = 32'(item.step_slot) < 32'(tss_pkg::TABLE_STEPS);
    assign index_inc      = current_index_reg + 9'd1;
    assign len_sat        = (32'(item.seq_length) > 32'(tss_pkg::MAX_LENGTH))
                          ? 9'(tss_pkg::MAX_LENGTH) : item.seq_length;

    assign wr_entry.frequency = item.step_frequency;
    assign wr_entry.duration  = item.step_duration;
    assign wr_entry.gap       = item.step_gap;

    assign ram_we    = accept && (item.kind == tss_pkg::KIND_WRITE) && slot_in_table;
    assign ram_waddr = tss_pkg::ADDR_W'(item.step_slot);
    assign ram_raddr = tss_pkg::ADDR_W'(current_index_next);

    always_comb
    begin
        if (!index_in_table)
        begin
            cur_entry = '0;
        end
        else if (fwd_hit_reg)
        begin
            cur_entry = fwd_data_reg;
        end
        else
        begin
            cur_entry = ram_rdata;
        end
    end

    tss_ram #(
        .WIDTH($bits(tss_pkg::step_entry_t)),
        .DEPTH(tss_pkg::TABLE_STEPS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(wr_entry),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        current_index_next     = current_index_reg;
        sequence_length_next   = sequence_length_reg;
        ticks_left_next        = ticks_left_reg;
        sounding_next          = sounding_reg;
        running_next           = running_reg;
        current_frequency_next = current_frequency_reg;

        if (cfg_write && !cfg_wdata)
        begin
            // disabling halts playback
            current_index_next     = '0;
            sequence_length_next   = '0;
            ticks_left_next        = '0;
            sounding_next          = 1'b0;
            running_next           = 1'b0;
            current_frequency_next = '0;
        end
        else if (accept)
        begin
            unique case (item.kind)
                tss_pkg::KIND_TICK:
                begin
                    if (running_reg)
                    begin
                        if (ticks_left_reg > 16'd1)
                        begin
                            ticks_left_next = ticks_left_reg - 16'd1;
                        end
                        else if (sounding_reg)
                        begin
                            // tone ends: advance and load the gap
                            sounding_next          = 1'b0;
                            current_frequency_next = '0;
                            current_index_next     = index_inc;
                            if (index_inc >= sequence_length_reg)
                            begin
                                running_next    = 1'b0;
                                ticks_left_next = '0;
                            end
                            else
                            begin
                                ticks_left_next = cur_entry.gap;
                            end
                        end
                        else if (current_index_reg >= sequence_length_reg
                                 || cur_entry.frequency == 16'd0
                                 || cur_entry.duration == 16'd0)
                        begin
                            running_next           = 1'b0;
                            sounding_next          = 1'b0;
                            current_frequency_next = '0;
                        end
                        else
                        begin
                            sounding_next          = 1'b1;
                            current_frequency_next = cur_entry.frequency;
                            ticks_left_next        = cur_entry.duration;
                        end
                    end
                end
                tss_pkg::KIND_WRITE:
                begin
                end
                tss_pkg::KIND_START:
                begin
                    if (enable_reg && item.seq_length != 9'd0)
                    begin
                        current_index_next   = '0;
                        sequence_length_next = len_sat;
                        ticks_left_next      = '0;
                        if (entry0_reg.frequency == 16'd0 || entry0_reg.duration == 16'd0)
                        begin
                            running_next           = 1'b0;
                            sounding_next          = 1'b0;
                            current_frequency_next = '0;
                        end
                        else
                        begin
                            running_next           = 1'b1;
                            sounding_next          = 1'b1;
                            current_frequency_next = entry0_reg.frequency;
                            ticks_left_next        = entry0_reg.duration;
                        end
                    end
                end
                tss_pkg::KIND_STOP:
                begin
                    current_index_next     = '0;
                    sequence_length_next   = '0;
                    ticks_left_next        = '0;
                    sounding_next          = 1'b0;
                    running_next           = 1'b0;
                    current_frequency_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push_data.tone_on        = sounding_next;
    assign push_data.tone_frequency = sounding_next ? current_frequency_next : 16'd0;
    assign push_data.playing        = running_next;
    assign push_data.step_index     = current_index_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg            <= 1'b1;
            current_index_reg     <= '0;
            sequence_length_reg   <= '0;
            ticks_left_reg        <= '0;
            sounding_reg          <= 1'b0;
            running_reg           <= 1'b0;
            current_frequency_reg <= '0;
            fwd_hit_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                enable_reg <= cfg_wdata;
            end
            current_index_reg     <= current_index_next;
            sequence_length_reg   <= sequence_length_next;
            ticks_left_reg        <= ticks_left_next;
            sounding_reg          <= sounding_next;
            running_reg           <= running_next;
            current_frequency_reg <= current_frequency_next;
            // bypass a write that lands on the entry being read ahead
            fwd_hit_reg           <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_entry;
        if (ram_we && item.step_slot == 8'd0)
        begin
            entry0_reg <= wr_entry;
        end
    end

    tss_out_skid u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .push_data   (push_data),
        .space       (item_ready),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

// File: design/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/tss_out_skid.sv
// Result register with a skid stage, so the producer can push one more result while the output is stalled.
module tss_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tss_pkg::result_t  push_data,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output tss_pkg::result_t  result
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    tss_pkg::result_t out_data_reg;
    tss_pkg::result_t skid_data_reg;

    assign space        = !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// File: tb/sv/tss_checker.sv
// Checker for the tone step sequencer: predicts every result and compares it.
`timescale 1ns / 1ps
module tss_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  tss_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  tss_pkg::result_t result,
    input  logic             cfg_write,
    input  logic             cfg_wdata,
    output int unsigned      fail_count,
    output int unsigned      pending_results,
    output logic             run_active
);

    tss_pkg::step_entry_t steps_q [tss_pkg::TABLE_STEPS];
    logic                 enable_q;
    logic [8:0]           index_q;
    logic [8:0]           length_q;
    logic [15:0]          left_q;
    logic                 sounding_q;
    logic                 running_q;
    logic [15:0]          freq_q;
    tss_pkg::result_t     tones_due [$];
    int unsigned          misses;

    assign fail_count = misses;

    task automatic report(input string msg);
        $display("%0t tss_checker: %s", $time, msg);
        misses++;
    endtask

    task automatic silence_all();
        sounding_q = 1'b0;
        running_q  = 1'b0;
        index_q    = '0;
        length_q   = '0;
        left_q     = '0;
        freq_q     = '0;
    endtask

    // Load frequency and on-time of the step at index_q, or end the run.
    task automatic open_step();
        tss_pkg::step_entry_t e;
        e = '0;
        if (index_q < tss_pkg::TABLE_STEPS)
            e = steps_q[index_q];
        if (!running_q || index_q >= length_q || e.frequency == 0 || e.duration == 0)
        begin
            running_q  = 1'b0;
            sounding_q = 1'b0;
            freq_q     = '0;
        end
        else
        begin
            sounding_q = 1'b1;
            freq_q     = e.frequency;
            left_q     = e.duration;
        end
    endtask

    task automatic count_tick();
        logic [15:0] g;
        g = '0;
        if (running_q)
        begin
            if (left_q > 1)
                left_q = left_q - 1'b1;
            else if (sounding_q)
            begin
                // the gap is read when the tone ends
                if (index_q < tss_pkg::TABLE_STEPS)
                    g = steps_q[index_q].gap;
                sounding_q = 1'b0;
                freq_q     = '0;
                index_q    = index_q + 1'b1;
                if (index_q >= length_q)
                begin
                    running_q = 1'b0;
                    left_q    = '0;
                end
                else
                    left_q = g;
            end
            else
                open_step();
        end
    endtask

    task automatic apply_item(input tss_pkg::item_t it);
        tss_pkg::result_t r;
        case (it.kind)
            tss_pkg::KIND_TICK:  count_tick();
            tss_pkg::KIND_WRITE:
            begin
                if (it.step_slot < tss_pkg::TABLE_STEPS)
                    steps_q[it.step_slot] = '{it.step_frequency, it.step_duration, it.step_gap};
            end
            tss_pkg::KIND_START:
            begin
                if (enable_q && it.seq_length != 0)
                begin
                    silence_all();
                    length_q  = (it.seq_length > tss_pkg::MAX_LENGTH)
                              ? 9'(tss_pkg::MAX_LENGTH) : it.seq_length;
                    index_q   = '0;
                    running_q = 1'b1;
                    open_step();
                end
            end
            tss_pkg::KIND_STOP:  silence_all();
        endcase
        r.tone_on        = sounding_q;
        r.tone_frequency = sounding_q ? freq_q : 16'd0;
        r.playing        = running_q;
        r.step_index     = index_q;
        tones_due.push_back(r);
    endtask

    task automatic check_result(input tss_pkg::result_t got);
        tss_pkg::result_t want;
        if (tones_due.size() == 0)
            report($sformatf("unexpected transaction: tone_on %0h freq %0h playing %0h index %0h",
                             got.tone_on, got.tone_frequency, got.playing, got.step_index));
        else
        begin
            want = tones_due.pop_front();
            if (got.tone_on !== want.tone_on)
                report($sformatf("tone_on got %0h want %0h", got.tone_on, want.tone_on));
            if (got.tone_frequency !== want.tone_frequency)
                report($sformatf("tone_frequency got %0h want %0h",
                                 got.tone_frequency, want.tone_frequency));
            if (got.playing !== want.playing)
                report($sformatf("playing got %0h want %0h", got.playing, want.playing));
            if (got.step_index !== want.step_index)
                report($sformatf("step_index got %0h want %0h", got.step_index, want.step_index));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_q = 1'b1;
            silence_all();
            tones_due.delete();
            misses          = 0;
            pending_results <= 0;
            run_active      <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (cfg_write)
            begin
                enable_q = cfg_wdata;
                // disabling drops any playback
                if (!cfg_wdata)
                    silence_all();
            end
            if (item_valid && item_ready)
                apply_item(item);
            pending_results <= tones_due.size();
            run_active      <= running_q;
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the tone step sequencer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;

    localparam int LIMIT_NS    = 8_000_000;
    localparam int HOLD_AT     = 1300;
    localparam int HOLD_CYCLES = 400;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    tss_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    tss_pkg::result_t result;
    logic             cfg_write;
    logic             cfg_wdata;

    int unsigned fail_count;
    int unsigned pending_results;
    logic        run_active;

    logic        hold_off;
    int unsigned items_sent;
    bit          enable_now;
    bit          start_live;
    bit          send_calm;
    bit          take_calm;

    tone_step_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata)
    );

    tss_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cfg_write       (cfg_write),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .run_active      (run_active)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : run_limit
        #(LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

    function automatic int unsigned draw_wait(input bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic tss_pkg::item_t make_item(input tss_pkg::kind_t k,
                                                 input logic [7:0] slot,
                                                 input logic [15:0] f, input logic [15:0] d,
                                                 input logic [15:0] g, input logic [8:0] len);
        tss_pkg::item_t it;
        it.kind           = k;
        it.step_slot      = slot;
        it.step_frequency = f;
        it.step_duration  = d;
        it.step_gap       = g;
        it.seq_length     = len;
        return it;
    endfunction

    function automatic tss_pkg::item_t noise_item();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return tss_pkg::item_t'(noise[$bits(tss_pkg::item_t)-1:0]);
    endfunction

    // Mostly short on-times and gaps so that runs move on; now and then full range.
    function automatic tss_pkg::item_t random_write(input logic [7:0] slot);
        tss_pkg::item_t it;
        int unsigned    r;
        it           = noise_item();
        it.kind      = tss_pkg::KIND_WRITE;
        it.step_slot = slot;
        it.step_frequency = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom);
        r = $urandom_range(0, 31);
        if (r == 0)
            it.step_duration = 16'd0;
        else if (r == 1)
            it.step_duration = 16'($urandom);
        else
            it.step_duration = 16'($urandom_range(1, 4));
        r = $urandom_range(0, 31);
        if (r == 0)
            it.step_gap = 16'($urandom);
        else if (r < 4)
            it.step_gap = 16'd0;
        else
            it.step_gap = 16'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic logic [8:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 9'd0;
            1:       return 9'($urandom_range(256, 511));
            2:       return 9'($urandom_range(0, 511));
            3:       return 9'($urandom_range(9, 64));
            default: return 9'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic tss_pkg::item_t random_item(input bit live);
        tss_pkg::item_t it;
        int unsigned    r;
        it = noise_item();
        r  = $urandom_range(0, 99);
        if (live ? r < 80 : r < 15)
            it.kind = tss_pkg::KIND_TICK;
        else if (live ? r < 90 : r < 35)
            it = random_write(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom_range(0, 255)));
        else if (live ? r < 97 : r < 93)
        begin
            it.kind       = tss_pkg::KIND_START;
            it.seq_length = pick_length();
        end
        else
            it.kind = tss_pkg::KIND_STOP;
        return it;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_item(input tss_pkg::item_t it);
        int unsigned gap_n;
        if ($urandom_range(0, 15) == 0)
            send_calm = !send_calm;
        gap_n = draw_wait(send_calm);
        if (gap_n != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap_n) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        items_sent++;
        start_live = (it.kind == tss_pkg::KIND_START) && enable_now && (it.seq_length != 0);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic write_enable(input logic value);
        drain();
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_write  <= 1'b0;
        enable_now = value;
        if (!value)
            start_live = 1'b0;
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned    counted;
        tss_pkg::item_t it;
        bit             live;
        counted = 0;
        while (counted < target)
        begin
            live = start_live || run_active;
            it   = random_item(live);
            send_item(it);
            // ticks while nothing plays are ignored by the block
            if (it.kind != tss_pkg::KIND_TICK || live)
                counted++;
        end
    endtask

    // Slots 0 and 1 play; slot 2 or 3, the run length or a stop always ends the run before any unwritten entry.
    task automatic directed_run();
        tss_pkg::item_t tick_it;
        tick_it = make_item(tss_pkg::KIND_TICK, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0);
        send_item(tick_it);
        send_item(make_item(tss_pkg::KIND_WRITE, 8'd0, 16'hFFFF, 16'd2, 16'd0, 9'd0));
        send_item(make_item(tss_pkg::KIND_WRITE, 8'd1, 16'h0001, 16'd1, 16'd2, 9'd0));
        send_item(make_item(tss_pkg::KIND_WRITE, 8'd2, 16'h1234, 16'd0, 16'd0, 9'd0));
        send_item(make_item(tss_pkg::KIND_START, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0));
        send_item(make_item(tss_pkg::KIND_START, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            9'h1FF));
        repeat (6) send_item(tick_it);
        send_item(make_item(tss_pkg::KIND_START, 8'd0, 16'd0, 16'd0, 16'd0, 9'd1));
        repeat (2) send_item(tick_it);
        send_item(make_item(tss_pkg::KIND_WRITE, 8'd3, 16'd0, 16'd5, 16'd0, 9'd0));
        send_item(make_item(tss_pkg::KIND_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            9'd0));
        send_item(make_item(tss_pkg::KIND_START, 8'd0, 16'd0, 16'd0, 16'd0, 9'd4));
        send_item(tick_it);
        send_item(make_item(tss_pkg::KIND_WRITE, 8'd2, 16'd7, 16'd1, 16'd0, 9'd0));
        send_item(tick_it);
        send_item(make_item(tss_pkg::KIND_START, 8'd0, 16'd0, 16'd0, 16'd0, 9'd2));
        send_item(make_item(tss_pkg::KIND_STOP, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0));
        write_enable(1'b0);
        send_item(make_item(tss_pkg::KIND_START, 8'd0, 16'd0, 16'd0, 16'd0, 9'd1));
        write_enable(1'b1);
    endtask

    initial
    begin : take_side
        int unsigned stall;
        stall        = 0;
        take_calm    = 1'b0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if ($urandom_range(0, 15) == 0)
                    take_calm = !take_calm;
                stall = draw_wait(take_calm);
            end
            else if (stall > 0)
                stall = stall - 1;
            result_ready <= (stall == 0) && !hold_off;
        end
    end

    // Hold the result side off for a long stretch so that the block backs up.
    initial
    begin : hold_stretch
        hold_off <= 1'b0;
        wait (items_sent >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        items_sent = 0;
        enable_now = 1'b1;
        start_live = 1'b0;
        send_calm  = 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_write  <= 1'b0;
        cfg_wdata  <= 1'b1;
        rst_n      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_enable(1'b1);
        directed_run();
        // fill every entry so that no run can reach an unwritten one
        for (int s = 0; s < 256; s++)
            send_item(random_write(8'(s)));
        random_phase(550);
        write_enable(1'b0);
        repeat (60) send_item(random_item(1'b0));
        write_enable(1'b1);
        random_phase(550);
        write_enable(1'b0);
        write_enable(1'b1);
        random_phase(450);
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
